/* src/mrrb_pkg.sv */
// Shared constants, types and helper functions of the multi-reader ring buffer.
`default_nettype none

package mrrb_pkg;

	// Sizing of the ring bank.
	localparam int NUM_VARIABLES = 16;
	localparam int NUM_READERS   = 4;
	localparam int RING_DEPTH    = 8;
	localparam int VALUE_WIDTH   = 32;

	// Only the four mask bits of a variable can name a reader.
	localparam int RD_LANES = (NUM_READERS < 4) ? NUM_READERS : 4;
	localparam int VIDX_W   = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
	localparam int RIDX_W   = (RD_LANES > 1) ? $clog2(RD_LANES) : 1;
	localparam int PTR_W    = $clog2(RING_DEPTH);
	localparam int CNT_W    = $clog2(RING_DEPTH + 1);
	localparam int RL_W     = $clog2(RD_LANES + 1);
	localparam int SLOTS    = NUM_VARIABLES * RING_DEPTH;
	localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [63:0] MASK_RESET = 64'd901506189704942;

	// Status codes of a result.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_NOSUB = 2'd3;

	// Commands.
	localparam logic CMD_PRODUCE = 1'b0;
	localparam logic CMD_CONSUME = 1'b1;

	// One reader's position in a variable's ring.
	typedef struct packed {
		logic [PTR_W-1:0] ptr;
		logic [CNT_W-1:0] unread;
	} rdr_entry_t;

	// All readers of one variable, held in one memory row.
	typedef rdr_entry_t [RD_LANES-1:0] rdr_row_t;

	// One slot of a ring.
	typedef struct packed {
		logic [VALUE_WIDTH-1:0] data;
		logic [RL_W-1:0]        left;
	} slot_entry_t;

	// Access request to the reader bank.
	typedef struct packed {
		logic              rd_en;
		logic [VIDX_W-1:0] rd_addr;
		logic              wr_en;
		logic [VIDX_W-1:0] wr_addr;
	} rdr_req_t;

	// Subscriber mask of a variable; variables past the bank have none.
	function automatic logic [3:0] subscribers(input logic [63:0] masks, input logic [3:0] v);
		logic [3:0] m;
		m = masks[{v, 2'b00} +: 4];
		if (int'(v) >= NUM_VARIABLES) begin
			m = '0;
		end
		for (int k = 0; k < 4; k++) begin
			if (k >= NUM_READERS) begin
				m[k] = 1'b0;
			end
		end
		return m;
	endfunction

	// Ring pointer advance with wrap at the ring depth.
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (int'(p) == RING_DEPTH - 1) begin
			n = '0;
		end else begin
			n = p + PTR_W'(1);
		end
		return n;
	endfunction

	// A stored word keeps its low VALUE_WIDTH bits.
	function automatic logic [VALUE_WIDTH-1:0] to_store(input logic [31:0] v);
		logic [63:0] t;
		t = {32'd0, v};
		return t[VALUE_WIDTH-1:0];
	endfunction

	// A returned word keeps the low 32 bits of the stored word.
	function automatic logic [31:0] from_store(input logic [VALUE_WIDTH-1:0] v);
		logic [63:0] t;
		t = 64'(v);
		return t[31:0];
	endfunction

endpackage

`default_nettype wire

/* src/mrrb_reader_bank.sv */
// Reader position memory: one row per variable, with row valid bits for reset.
`default_nettype none

module mrrb_reader_bank (
	input  wire                clk,
	input  wire                arst_n,
	input  mrrb_pkg::rdr_req_t req,
	input  mrrb_pkg::rdr_row_t wr_row,
	output mrrb_pkg::rdr_row_t rd_row
);
	import mrrb_pkg::*;

	rdr_row_t mem [NUM_VARIABLES];
	logic     vld_q [NUM_VARIABLES];
	rdr_row_t rd_data_q;
	logic     rd_vld_q;

	// Row valid bits: a row never written reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VARIABLES; i++) begin
				vld_q[i] <= 1'b0;
			end
			rd_vld_q <= 1'b0;
		end else begin
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	// Memory array with a registered read port that holds between reads.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_row;
		end
	end

	assign rd_row = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

/* src/multi_reader_ring_buffer_top.sv */
// Top level of the multi-reader ring buffer: control, slot memory and result register.
// A result is registered in the slot step, after the reader row step that follows
// the transfer of its command. A new command waits until the last one is done, set by
// the two dependent memory reads (reader row, then slot) and their write-back.
// A stalled result holds the block in its last step; a new command is taken at idle.
// Reset is asynchronous; valid bits make reader rows and slot reader counts read zero.
`default_nettype none

module multi_reader_ring_buffer_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire  [63:0] cfg_wr_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         cmd,
	input  wire  [3:0]  var_id,
	input  wire  [1:0]  reader_id,
	input  wire  [31:0] value,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [31:0] read_value,
	output logic [1:0]  status
);
	import mrrb_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RDR  = 2'd1;
	localparam logic [1:0] S_SLOT = 2'd2;

	logic [1:0]  state_q;
	logic [63:0] masks_q;

	logic        cmd_q;
	logic [3:0]  var_q;
	logic [1:0]  reader_q;
	logic [31:0] val_q;
	logic [SLOT_W-1:0] slot_idx_q;

	logic [PTR_W-1:0] wp_q   [NUM_VARIABLES];
	logic [CNT_W-1:0] free_q [NUM_VARIABLES];

	slot_entry_t slot_mem [SLOTS];
	logic        slot_vld_q [SLOTS];
	slot_entry_t slot_rd_q;
	logic        slot_rd_vld_q;
	slot_entry_t slot_rd;

	logic        out_valid_q;
	logic [31:0] read_value_q;
	logic [1:0]  status_q;

	rdr_req_t rdr_req;
	rdr_row_t rdr_row;
	rdr_row_t row_new;

	logic              in_xfer;
	logic              finish;
	logic [VIDX_W-1:0] vidx;
	logic [RIDX_W-1:0] lane;
	logic              var_ok;
	logic [3:0]        mask;
	logic              sub_ok;
	logic [PTR_W-1:0]  ptr_sel;
	logic [SLOT_W-1:0] slot_idx;
	logic              slot_rd_en;

	slot_entry_t      slot_new;
	logic [CNT_W-1:0] free_new;
	logic [PTR_W-1:0] wp_new;
	logic             slot_wr;
	logic             rdr_wr;
	logic             var_wr;
	logic [31:0]      rv;
	logic [1:0]       stat;

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign finish   = (state_q == S_SLOT) && (!out_valid_q || out_ready);

	assign vidx   = VIDX_W'(var_q);
	assign lane   = reader_q[RIDX_W-1:0];
	assign var_ok = int'(var_q) < NUM_VARIABLES;
	assign mask   = subscribers(masks_q, var_q);
	assign sub_ok = (int'(reader_q) < NUM_READERS) && mask[reader_q];

	// Subscriber mask register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_q <= MASK_RESET;
		end else if (cfg_wr_en) begin
			masks_q <= cfg_wr_data;
		end
	end

	// Sequencer: accept, read reader row, read slot, write back and deliver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_RDR;
					end
				end
				S_RDR: begin
					state_q <= S_SLOT;
				end
				S_SLOT: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command capture at the input transfer, slot address at the reader row step.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q    <= cmd;
			var_q    <= var_id;
			reader_q <= reader_id;
			val_q    <= value;
		end
		if (slot_rd_en) begin
			slot_idx_q <= slot_idx;
		end
	end

	// Reader bank access: read at the transfer, write back at the last step.
	always_comb begin
		rdr_req.rd_en   = in_xfer;
		rdr_req.rd_addr = VIDX_W'(var_id);
		rdr_req.wr_en   = finish && rdr_wr;
		rdr_req.wr_addr = vidx;
	end

	mrrb_reader_bank u_reader_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rdr_req),
		.wr_row (row_new),
		.rd_row (rdr_row)
	);

	// Slot address: the reader's pointer on consume, the write pointer on produce.
	always_comb begin
		ptr_sel    = (cmd_q == CMD_CONSUME) ? rdr_row[lane].ptr : wp_q[vidx];
		slot_idx   = SLOT_W'(int'(vidx) * RING_DEPTH + int'(ptr_sel));
		slot_rd_en = (state_q == S_RDR);
	end

	// Slot valid bits: a slot never written has no readers left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_vld_q[i] <= 1'b0;
			end
			slot_rd_vld_q <= 1'b0;
		end else begin
			if (slot_rd_en) begin
				slot_rd_vld_q <= slot_vld_q[slot_idx];
			end
			if (finish && slot_wr) begin
				slot_vld_q[slot_idx_q] <= 1'b1;
			end
		end
	end

	// Slot memory with a registered read port.
	always_ff @(posedge clk) begin
		if (slot_rd_en) begin
			slot_rd_q <= slot_mem[slot_idx];
		end
		if (finish && slot_wr) begin
			slot_mem[slot_idx_q] <= slot_new;
		end
	end

	always_comb begin
		slot_rd = slot_rd_q;
		if (!slot_rd_vld_q) begin
			slot_rd.left = '0;
		end
	end

	// Command evaluation on the fetched reader row and slot.
	always_comb begin
		row_new  = rdr_row;
		slot_new = slot_rd;
		free_new = free_q[vidx];
		wp_new   = wp_q[vidx];
		slot_wr  = 1'b0;
		rdr_wr   = 1'b0;
		var_wr   = 1'b0;
		rv       = '0;
		stat     = STAT_OK;
		if (cmd_q == CMD_PRODUCE) begin
			if (!var_ok) begin
				stat = STAT_NOSUB;
			end else if (free_q[vidx] == '0) begin
				stat = STAT_FULL;
			end else if (mask == 4'd0) begin
				stat = STAT_NOSUB;
			end else begin
				slot_new.data = to_store(val_q);
				slot_new.left = RL_W'($countones(mask));
				wp_new   = ptr_next(wp_q[vidx]);
				free_new = free_q[vidx] - CNT_W'(1);
				for (int k = 0; k < RD_LANES; k++) begin
					if (mask[k] && int'(rdr_row[k].unread) < RING_DEPTH) begin
						row_new[k].unread = rdr_row[k].unread + CNT_W'(1);
					end
				end
				slot_wr = 1'b1;
				rdr_wr  = 1'b1;
				var_wr  = 1'b1;
			end
		end else begin
			if (!sub_ok) begin
				stat = STAT_NOSUB;
			end else if (rdr_row[lane].unread == '0) begin
				stat = STAT_EMPTY;
			end else begin
				rv = from_store(slot_rd.data);
				// A slot already at zero readers is not freed again.
				if (slot_rd.left != '0) begin
					slot_new.left = slot_rd.left - RL_W'(1);
					if (slot_new.left == '0 && int'(free_q[vidx]) < RING_DEPTH) begin
						free_new = free_q[vidx] + CNT_W'(1);
					end
				end
				row_new[lane].ptr    = ptr_next(rdr_row[lane].ptr);
				row_new[lane].unread = rdr_row[lane].unread - CNT_W'(1);
				slot_wr = 1'b1;
				rdr_wr  = 1'b1;
				var_wr  = var_ok;
			end
		end
	end

	// Per-variable write pointers and free slot counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VARIABLES; i++) begin
				wp_q[i]   <= '0;
				free_q[i] <= CNT_W'(RING_DEPTH);
			end
		end else if (finish && var_wr) begin
			wp_q[vidx]   <= wp_new;
			free_q[vidx] <= free_new;
		end
	end

	// Result register: a finished result waits here for its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			read_value_q <= rv;
			status_q     <= stat;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

	// A command transfer always starts the reader row step.
	a_xfer_to_rdr: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == S_RDR))
		else $error("command transfer did not start the reader row step");

	// A stalled result keeps the last step waiting.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SLOT && out_valid_q && !out_ready) |=> (state_q == S_SLOT))
		else $error("last step left while the result register was blocked");

	// Refused commands and produces return a zero word.
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STAT_OK || $past(cmd_q) == CMD_PRODUCE) && $rose(out_valid))
		|-> (read_value == 32'd0))
		else $error("nonzero read value on a refused or produce result");

	// The free slot count of the addressed variable never passes the ring depth.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SLOT && var_ok) |-> (int'(free_q[vidx]) <= RING_DEPTH))
		else $error("free slot count above ring depth");

endmodule

`default_nettype wire
